@@ rtl/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

  // Fixed field widths of the request and result items
  localparam int unsigned OP_W    = 1;
  localparam int unsigned SLOT_W  = 2;
  localparam int unsigned PAGE_W  = 12;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned STAT_W  = 2;

  // Bitmap word geometry
  localparam int unsigned BMW_W  = 32;
  localparam int unsigned BIT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 1'b0,
    OP_DISPOSE = 1'b1
  } bpa_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } bpa_status_e;

  // Result of the lowest-clear-bit search over one bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bpa_zero_t;

  function automatic bpa_zero_t bpa_lowest_zero(input logic [BMW_W-1:0] word);
    bpa_zero_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = BMW_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bpa_word_store.sv @@
`default_nettype none

// Bitmap word store: one write and one registered read per cycle.
// Word 0 of each slot reads as "header in use" until that word is first written;
// every other word is written before it is ever read.
module bpa_word_store
  import bpa_pkg::*;
#(
  parameter int unsigned Slots = 4,
  parameter int unsigned Words = 128,
  parameter int unsigned SlotW = 2,
  parameter int unsigned WordW = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             re_i,
  input  wire logic [SlotW-1:0] rd_slot_i,
  input  wire logic [WordW-1:0] rd_word_i,
  output logic      [BMW_W-1:0] rdata_o,
  input  wire logic             we_i,
  input  wire logic [SlotW-1:0] wr_slot_i,
  input  wire logic [WordW-1:0] wr_word_i,
  input  wire logic [BMW_W-1:0] wdata_i
);

  localparam int unsigned Depth = Slots * Words;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [BMW_W-1:0] mem_q [Depth];
  logic [BMW_W-1:0] raw_q;
  logic             hdr_dflt_q;
  logic [Slots-1:0] hdr_written_q;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] waddr;

  assign raddr = AddrW'(rd_slot_i) * AddrW'(Words) + AddrW'(rd_word_i);
  assign waddr = AddrW'(wr_slot_i) * AddrW'(Words) + AddrW'(wr_word_i);

  // Storage array, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr] <= wdata_i;
    end
    if (re_i) begin
      raw_q <= mem_q[raddr];
    end
  end

  // Header word flags per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_written_q <= '0;
      hdr_dflt_q    <= 1'b0;
    end else begin
      if (we_i && (wr_word_i == '0)) begin
        hdr_written_q[wr_slot_i] <= 1'b1;
      end
      if (re_i) begin
        hdr_dflt_q <= (rd_word_i == '0) && !hdr_written_q[rd_slot_i];
      end
    end
  end

  assign rdata_o = hdr_dflt_q ? BMW_W'(1) : raw_q;

endmodule

`default_nettype wire

@@ rtl/bitmap_page_allocator.sv @@
`default_nettype none

// Bitmap page allocator. Each file slot keeps a page-use bitmap in a
// single-port-write, registered-read word store, plus a high-water page count
// and an allocated count in flip-flops; page 0 starts in use. One item is
// worked at a time, through a decide step, an optional modify step and a
// result step. A dispose skips the modify step when the page lies at or above
// the high-water mark; an allocate that extends the high-water mark skips it
// unless the new page falls inside a partly used word; an allocate that fills
// a hole scans the slot's bitmap one 32-bit word per cycle through the store's
// read port in the modify step, up to MAX_PAGES/32 words (128 at the default),
// and reads one word more if the scan finds no hole and the mark then grows
// inside a partly used word. A finished result waits in an output register
// and a new item is accepted while it waits; that item then holds in its last
// step until the register is free. No clearing pass is needed after reset.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int unsigned MAX_PAGES  = 4096,
  parameter int unsigned FILE_SLOTS = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [SLOT_W-1:0]  file_slot_i,
  input  wire logic [PAGE_W-1:0]  page_number_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [PAGE_W-1:0]       granted_page_o,
  output logic [STAT_W-1:0]       status_o,
  output logic [COUNT_W-1:0]      pages_in_use_o
);

  localparam int unsigned Words = (MAX_PAGES + BMW_W - 1) / BMW_W;
  localparam int unsigned SlotW = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int unsigned WordW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned CntW  = $clog2(MAX_PAGES + 1);
  localparam int unsigned WideW = (CntW > PAGE_W) ? CntW : PAGE_W;
  localparam int unsigned NxtW  = CntW + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_MODIFY = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  typedef enum logic [1:0] {
    K_SCAN = 2'd0,
    K_EXT  = 2'd1,
    K_DISP = 2'd2
  } kind_e;

  state_e state_q, state_d;
  kind_e  kind_q, kind_d;

  logic [OP_W-1:0]   op_q;
  logic [SlotW-1:0]  slot_q;
  logic [PAGE_W-1:0] page_q;
  logic [WordW-1:0]  word_q;

  logic [CntW-1:0] hw_q    [FILE_SLOTS];
  logic [CntW-1:0] alloc_q [FILE_SLOTS];

  logic [PAGE_W-1:0] res_page_q, res_page_d;
  logic [STAT_W-1:0] res_stat_q, res_stat_d;

  logic               out_valid_q;
  logic [PAGE_W-1:0]  out_page_q;
  logic [STAT_W-1:0]  out_stat_q;
  logic [COUNT_W-1:0] out_cnt_q;

  // Word store ports
  logic             re;
  logic [WordW-1:0] rd_word;
  logic [BMW_W-1:0] rdata;
  logic             we;
  logic [WordW-1:0] wr_word;
  logic [BMW_W-1:0] wdata;

  logic hw_inc, alloc_inc, alloc_dec;
  logic out_load;
  logic accept;

  logic [SLOT_W-1:0] slot_in;
  logic [CntW-1:0]   hw_cur;
  logic [CntW-1:0]   al_cur;
  logic [CntW-1:0]   page_cnt;
  logic [CntW-1:0]   scan_page;
  logic [NxtW-1:0]   nxt_base;
  logic [BIT_W-1:0]  bit_sel;
  bpa_zero_t         zero;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign hw_cur    = hw_q[slot_q];
  assign al_cur    = alloc_q[slot_q];
  assign page_cnt  = CntW'(page_q);
  assign zero      = bpa_lowest_zero(rdata);
  assign scan_page = CntW'({word_q, zero.idx});
  assign nxt_base  = NxtW'({word_q, BIT_W'(0)}) + NxtW'(BMW_W);

  // Slot wrap into range by repeated compare and subtract
  always_comb begin
    slot_in = file_slot_i;
    for (int k = 0; k < (1 << SLOT_W); k++) begin
      if (32'(slot_in) >= FILE_SLOTS) begin
        slot_in = slot_in - SLOT_W'(FILE_SLOTS);
      end
    end
  end

  bpa_word_store #(
    .Slots (FILE_SLOTS),
    .Words (Words),
    .SlotW (SlotW),
    .WordW (WordW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (re),
    .rd_slot_i (slot_q),
    .rd_word_i (rd_word),
    .rdata_o   (rdata),
    .we_i      (we),
    .wr_slot_i (slot_q),
    .wr_word_i (wr_word),
    .wdata_i   (wdata)
  );

  // Sequencer: decide, read-modify-write, result
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    res_page_d = res_page_q;
    res_stat_d = res_stat_q;
    re         = 1'b0;
    rd_word    = word_q;
    we         = 1'b0;
    wr_word    = word_q;
    wdata      = rdata;
    hw_inc     = 1'b0;
    alloc_inc  = 1'b0;
    alloc_dec  = 1'b0;
    bit_sel    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_stat_d = ST_OK;
        if (op_q == OP_DISPOSE) begin
          res_page_d = page_q;
          if (WideW'(page_q) >= WideW'(hw_cur)) begin
            res_stat_d = ST_NOT_ALLOC;
            state_d    = S_DONE;
          end else begin
            re      = 1'b1;
            rd_word = WordW'(page_cnt >> BIT_W);
            kind_d  = K_DISP;
            state_d = S_MODIFY;
          end
        end else if (al_cur < hw_cur) begin
          // holes below the mark: scan from word 0
          re      = 1'b1;
          rd_word = '0;
          kind_d  = K_SCAN;
          state_d = S_MODIFY;
        end else if (hw_cur >= CntW'(MAX_PAGES)) begin
          res_page_d = '0;
          res_stat_d = ST_FULL;
          state_d    = S_DONE;
        end else if (hw_cur[BIT_W-1:0] == '0) begin
          // extension opens a fresh word
          we         = 1'b1;
          wr_word    = WordW'(hw_cur >> BIT_W);
          wdata      = BMW_W'(1);
          hw_inc     = 1'b1;
          alloc_inc  = 1'b1;
          res_page_d = PAGE_W'(hw_cur);
          state_d    = S_DONE;
        end else begin
          re      = 1'b1;
          rd_word = WordW'(hw_cur >> BIT_W);
          kind_d  = K_EXT;
          state_d = S_MODIFY;
        end
      end

      S_MODIFY: begin
        unique case (kind_q)
          K_SCAN: begin
            if (zero.found && (scan_page < hw_cur)) begin
              we         = 1'b1;
              wdata      = rdata | (BMW_W'(1) << zero.idx);
              alloc_inc  = 1'b1;
              res_page_d = PAGE_W'(scan_page);
              state_d    = S_DONE;
            end else if (nxt_base < NxtW'(hw_cur)) begin
              re      = 1'b1;
              rd_word = word_q + WordW'(1);
            end else if (hw_cur >= CntW'(MAX_PAGES)) begin
              // no hole after all and no room to grow
              res_page_d = '0;
              res_stat_d = ST_FULL;
              state_d    = S_DONE;
            end else if (hw_cur[BIT_W-1:0] == '0) begin
              we         = 1'b1;
              wr_word    = WordW'(hw_cur >> BIT_W);
              wdata      = BMW_W'(1);
              hw_inc     = 1'b1;
              alloc_inc  = 1'b1;
              res_page_d = PAGE_W'(hw_cur);
              state_d    = S_DONE;
            end else begin
              re      = 1'b1;
              rd_word = WordW'(hw_cur >> BIT_W);
              kind_d  = K_EXT;
            end
          end
          K_EXT: begin
            bit_sel    = hw_cur[BIT_W-1:0];
            we         = 1'b1;
            wdata      = rdata | (BMW_W'(1) << bit_sel);
            hw_inc     = 1'b1;
            alloc_inc  = 1'b1;
            res_page_d = PAGE_W'(hw_cur);
            state_d    = S_DONE;
          end
          K_DISP: begin
            bit_sel = page_cnt[BIT_W-1:0];
            if (rdata[bit_sel]) begin
              we        = 1'b1;
              wdata     = rdata & ~(BMW_W'(1) << bit_sel);
              alloc_dec = (al_cur != '0);
            end else begin
              res_stat_d = ST_NOT_ALLOC;
            end
            state_d = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and per-slot counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= K_SCAN;
      out_valid_q <= 1'b0;
      for (int s = 0; s < FILE_SLOTS; s++) begin
        hw_q[s]    <= CntW'(1);
        alloc_q[s] <= CntW'(1);
      end
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (hw_inc) begin
        hw_q[slot_q] <= hw_cur + CntW'(1);
      end
      if (alloc_inc) begin
        alloc_q[slot_q] <= al_cur + CntW'(1);
      end else if (alloc_dec) begin
        alloc_q[slot_q] <= al_cur - CntW'(1);
      end
    end
  end

  // Request, scan position and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      slot_q <= SlotW'(slot_in);
      page_q <= page_number_i;
    end
    if (re) begin
      word_q <= rd_word;
    end
    res_page_q <= res_page_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_page_q <= res_page_q;
      out_stat_q <= res_stat_q;
      out_cnt_q  <= COUNT_W'(al_cur);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_page_o = out_page_q;
  assign status_o       = out_stat_q;
  assign pages_in_use_o = out_cnt_q;

endmodule

`default_nettype wire

@@ dv/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned MAX_PAGES  = 4096;
  localparam int unsigned FILE_SLOTS = 4;

  // One expected result item
  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    bpa_status_e        status;
    logic [COUNT_W-1:0] in_use;
  } grant_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [OP_W-1:0]    operation_i   = '0;
  logic [SLOT_W-1:0]  file_slot_i   = '0;
  logic [PAGE_W-1:0]  page_number_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [PAGE_W-1:0]  granted_page_o;
  logic [STAT_W-1:0]  status_o;
  logic [COUNT_W-1:0] pages_in_use_o;

  // Predicted allocator state, one page map per slot
  bit [MAX_PAGES-1:0] page_used  [FILE_SLOTS];
  logic [COUNT_W-1:0] hw_mark    [FILE_SLOTS];
  logic [COUNT_W-1:0] in_use_cnt [FILE_SLOTS];

  grant_t pending_grants[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int n_checked      = 0;
  int n_not_alloc    = 0;

  bitmap_page_allocator #(
    .MAX_PAGES  (MAX_PAGES),
    .FILE_SLOTS (FILE_SLOTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .file_slot_i    (file_slot_i),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_page_o (granted_page_o),
    .status_o       (status_o),
    .pages_in_use_o (pages_in_use_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Reset state of the predictor: only the header page in use
  function automatic void clear_page_maps();
    for (int s = 0; s < FILE_SLOTS; s++) begin
      page_used[s]    = '0;
      page_used[s][0] = 1'b1;
      hw_mark[s]      = COUNT_W'(1);
      in_use_cnt[s]   = COUNT_W'(1);
    end
  endfunction

  // Works out the result of one request and updates the predicted maps
  function automatic grant_t work_out_grant(bpa_op_e op, logic [SLOT_W-1:0] slot,
                                            logic [PAGE_W-1:0] page);
    grant_t g;
    bit     done;
    int     p;
    g.page   = '0;
    g.status = ST_OK;
    done     = 1'b0;
    if (op == OP_ALLOC) begin
      // holes below the high-water mark come first, lowest one wins
      if (in_use_cnt[slot] < hw_mark[slot]) begin
        for (p = 0; p < int'(hw_mark[slot]) && !done; p++) begin
          if (!page_used[slot][p]) begin
            page_used[slot][p] = 1'b1;
            in_use_cnt[slot]++;
            g.page = PAGE_W'(p);
            done   = 1'b1;
          end
        end
      end
      if (!done) begin
        if (hw_mark[slot] >= MAX_PAGES) begin
          g.status = ST_FULL;
        end else begin
          g.page = hw_mark[slot][PAGE_W-1:0];
          page_used[slot][hw_mark[slot]] = 1'b1;
          hw_mark[slot]++;
          in_use_cnt[slot]++;
        end
      end
    end else begin
      g.page = page;
      if (page >= hw_mark[slot] || !page_used[slot][page]) begin
        g.status = ST_NOT_ALLOC;
      end else begin
        page_used[slot][page] = 1'b0;
        if (in_use_cnt[slot] > 0) in_use_cnt[slot]--;
      end
    end
    g.in_use = in_use_cnt[slot];
    return g;
  endfunction

  // Sends one request item; valid drops only during an idle gap or in wait_drained
  task automatic send_item(bpa_op_e op, logic [SLOT_W-1:0] slot, logic [PAGE_W-1:0] page);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    file_slot_i   <= slot;
    page_number_i <= page;
    do @(posedge clk_i); while (!in_ready_o);
    pending_grants.push_back(work_out_grant(op, slot, page));
  endtask

  // Holds the sender off until every outstanding result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // Picks a page that is probably in use in the slot
  function automatic logic [PAGE_W-1:0] pick_used_page(logic [SLOT_W-1:0] slot);
    int p;
    p = 0;
    for (int t = 0; t < 8; t++) begin
      p = $urandom_range(int'(hw_mark[slot]) - 1, 0);
      if (page_used[slot][p]) return PAGE_W'(p);
    end
    return PAGE_W'(p);
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result page=%0d status=%0d in_use=%0d", $time,
                 granted_page_o, status_o, pages_in_use_o);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        n_checked++;
        if (want.status == ST_NOT_ALLOC) n_not_alloc++;
        if (granted_page_o !== want.page) begin
          $display("%0t: granted_page expected %0d actual %0d", $time,
                   want.page, granted_page_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatches++;
        end
        if (pages_in_use_o !== want.in_use) begin
          $display("%0t: pages_in_use expected %0d actual %0d", $time,
                   want.in_use, pages_in_use_o);
          mismatches++;
        end
      end
    end
  end

  // Header page, boundaries of the high-water mark, bit patterns
  task automatic test_header_and_edges();
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    send_item(OP_ALLOC, 2'd0, 12'hFFF);
    send_item(OP_ALLOC, 2'd1, 12'h000);
    send_item(OP_ALLOC, 2'd2, 12'h555);
    send_item(OP_ALLOC, 2'd3, 12'hAAA);
    // header can be freed and handed out again
    send_item(OP_DISPOSE, 2'd0, 12'd0);
    send_item(OP_DISPOSE, 2'd0, 12'd0);
    send_item(OP_ALLOC, 2'd0, 12'd0);
    // at and beyond the high-water mark
    send_item(OP_DISPOSE, 2'd1, 12'd2);
    send_item(OP_DISPOSE, 2'd1, 12'hFFF);
    // empty a slot completely, then refill its holes
    send_item(OP_DISPOSE, 2'd2, 12'd1);
    send_item(OP_DISPOSE, 2'd2, 12'd0);
    send_item(OP_DISPOSE, 2'd2, 12'd0);
    send_item(OP_ALLOC, 2'd2, 12'hFFF);
    send_item(OP_ALLOC, 2'd2, 12'd0);
    send_item(OP_ALLOC, 2'd2, 12'd7);
    send_item(OP_DISPOSE, 2'd3, 12'hAAA);
    send_item(OP_DISPOSE, 2'd3, 12'h555);
    wait_drained();
  endtask

  // Grows one slot over several bitmap words, then exercises deep scans
  task automatic test_deep_scan();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (hw_mark[3] < COUNT_W'(300)) send_item(OP_ALLOC, 2'd3, PAGE_W'($urandom));
    send_item(OP_DISPOSE, 2'd3, 12'd299);
    send_item(OP_DISPOSE, 2'd3, 12'd299);
    send_item(OP_DISPOSE, 2'd3, 12'd300);
    // hole in the last word
    send_item(OP_ALLOC, 2'd3, 12'd0);
    send_item(OP_DISPOSE, 2'd3, 12'd256);
    send_item(OP_DISPOSE, 2'd3, 12'd32);
    send_item(OP_DISPOSE, 2'd3, 12'd31);
    repeat (4) send_item(OP_ALLOC, 2'd3, 12'd0);
    wait_drained();
  endtask

  // Mostly allocate and free-of-used traffic, with stray disposes mixed in
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
    int                r;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] page;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      r    = $urandom_range(99);
      slot = SLOT_W'($urandom_range(FILE_SLOTS - 1));
      if (r < 48) begin
        send_item(OP_ALLOC, slot, PAGE_W'($urandom));
      end else if (r < 85) begin
        send_item(OP_DISPOSE, slot, pick_used_page(slot));
      end else begin
        case ($urandom_range(2))
          0:       page = PAGE_W'($urandom);
          1:       page = hw_mark[slot][PAGE_W-1:0];
          default: page = PAGE_W'($urandom_range(int'(hw_mark[slot]) - 1, 0));
        endcase
        send_item(OP_DISPOSE, slot, page);
      end
    end
    wait_drained();
  endtask

  initial begin
    clear_page_maps();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_header_and_edges();
    test_deep_scan();
    test_random_traffic(355, 0, 0);
    test_random_traffic(355, 64, 0);
    test_random_traffic(355, 0, 64);
    test_random_traffic(355, 15, 15);

    wait_drained();
    repeat (200) @(posedge clk_i);
    $display("Checked %0d results, %0d of them disposes of free pages,", n_checked,
             n_not_alloc);
    $display("with multi-word hole scans on one slot and four idling patterns.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pending_grants.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
